// ===== rtl/dlr_pkg.sv =====
// Package: shared types, constants and exp tables for the duration length regulator.
package dlr_pkg;

  // Sequence limits
  localparam int MAX_FRAMES = 1024;
  localparam int MAX_TOKENS = 256;
  localparam int TOKEN_WRAP = (MAX_TOKENS < 256) ? MAX_TOKENS : 256;

  // Field widths
  localparam int LOGD_W  = 12;
  localparam int SCALE_W = 16;
  localparam int IDX_W   = 8;
  localparam int DUR_W   = 10;
  localparam int FRAME_W = 11;
  localparam int TOTAL_W = 18;

  localparam int DUR_SAT   = (1 << DUR_W) - 1;
  localparam int TOTAL_SAT = (1 << TOTAL_W) - 1;

  // Exp datapath widths
  localparam int EI_W     = 35;   // e^k in Q.24, k in -8..7
  localparam int EF_W     = 30;   // e^(f/256) in Q.28
  localparam int EF_SPLIT = 15;   // EF is multiplied in two halves
  localparam int PROD_W   = EI_W + EF_W;
  localparam int EXP_W    = 36;   // e^x in Q.24
  localparam int EXP_SH   = 28;
  localparam int SCALED_W = EXP_W + SCALE_W;
  localparam int FR_SH    = 36;   // Q.24 times Q.12
  localparam int FRAMES_W = SCALED_W + 1 - FR_SH;

  localparam longint unsigned EXP_STEP_Q28 = 64'd269486083;

  typedef logic [EI_W-1:0] ei_table_t [0:15];
  typedef logic [EF_W-1:0] ef_table_t [0:255];

  localparam ei_table_t EI_TABLE = '{
    35'd5628, 35'd15299, 35'd41587, 35'd113044, 35'd307285, 35'd835288,
    35'd2270549, 35'd6171993, 35'd16777216, 35'd45605201, 35'd123967789,
    35'd336979391, 35'd916004956, 35'd2489959628, 35'd6768412009,
    35'd18398451372
  };

  // Fractional exp table: repeated rounded multiply by e^(1/256), built at elaboration
  function automatic ef_table_t build_ef_table();
    ef_table_t       tbl;
    longint unsigned acc;
    acc = 64'd1 << 28;
    for (int i = 0; i < 256; i++) begin
      tbl[i] = acc[EF_W-1:0];
      acc = (acc * EXP_STEP_Q28 + (64'd1 << 27)) >> 28;
    end
    return tbl;
  endfunction

  localparam ef_table_t EF_TABLE = build_ef_table();

  // One classified token waiting for the back end
  typedef struct packed {
    logic [EI_W-1:0] ei;
    logic [EF_W-1:0] ef;
    logic            real_tok;
    logic            last;
  } dlr_item_t;

  // Clip a frame position to the maximum frame count, keep the port width
  function automatic logic [FRAME_W-1:0] clip_frames(logic [TOTAL_W-1:0] v);
    logic [TOTAL_W-1:0] c;
    c = (v > TOTAL_W'(MAX_FRAMES)) ? TOTAL_W'(MAX_FRAMES) : v;
    return c[FRAME_W-1:0];
  endfunction

endpackage

// ===== rtl/duration_length_regulator.sv =====
// Top level of the duration length regulator: token stream in, span results out.
//
//  channel | dir | handshake            | payload
//  s_*     | in  | s_tvalid / s_tready  | tdata[11:0] log_duration, tuser token_valid,
//          |     |                      | tlast last_token
//  m_*     | out | m_tvalid / m_tready  | tdata token span and length, tlast is_last
//  cfg_*   | in  | cfg_we               | cfg_wdata speed_scale (Q4.12)
//
// A real token passes through the back end steps pop, two exp partial products,
// scale multiply and accumulate; a padding token goes from pop to accumulate.
// The 35x30 exp multiply is split in two. A two-entry queue lets the input take
// transfers while the back end works or the result waits. Reset (rst,
// synchronous) clears the queue, running frame total, token index and sets
// speed_scale to 1.0. A stalled result holds in the output register.
module duration_length_regulator
  import dlr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [SCALE_W-1:0] cfg_wdata,   // speed_scale
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [15:0]        s_tdata,     // [11:0] log_duration, [15:12] zero
  input  logic               s_tuser,     // token_valid
  input  logic               s_tlast,     // last_token
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [55:0]        m_tdata,     // token_index, duration_frames, start_frame,
                                          // end_frame, seq_length, truncated, zero fill
  output logic               m_tlast      // is_last
);

  dlr_item_t          push_item;
  dlr_item_t          head;
  logic               push;
  logic               pop;
  logic               q_full;
  logic               q_not_empty;
  logic [IDX_W-1:0]   token_index;
  logic [DUR_W-1:0]   duration_frames;
  logic [FRAME_W-1:0] start_frame;
  logic [FRAME_W-1:0] end_frame;
  logic [FRAME_W-1:0] seq_length;
  logic               truncated;

  dlr_front u_front (
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .log_duration (s_tdata[LOGD_W-1:0]),
    .token_valid  (s_tuser),
    .last_token   (s_tlast),
    .q_full       (q_full),
    .q_push       (push),
    .q_item       (push_item)
  );

  dlr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (head)
  );

  dlr_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .q_not_empty     (q_not_empty),
    .q_head          (head),
    .q_pop           (pop),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .token_index     (token_index),
    .duration_frames (duration_frames),
    .start_frame     (start_frame),
    .end_frame       (end_frame),
    .seq_length      (seq_length),
    .truncated       (truncated),
    .is_last         (m_tlast)
  );

  // Result packing, first field in the low bits
  assign m_tdata = {4'b0, truncated, seq_length, end_frame, start_frame,
                    duration_frames, token_index};

endmodule

// ===== rtl/dlr_front.sv =====
// Front end: accepts tokens and splits the log duration into exp table lookups.
module dlr_front
  import dlr_pkg::*;
(
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [LOGD_W-1:0] log_duration,
  input  logic              token_valid,
  input  logic              last_token,
  input  logic              q_full,
  output logic              q_push,
  output dlr_item_t         q_item
);

  logic [3:0] k_idx;
  logic [7:0] f_idx;

  // Offset binary: integer part selects e^k, fraction selects e^(f/256)
  assign k_idx = {~log_duration[LOGD_W-1], log_duration[LOGD_W-2:8]};
  assign f_idx = log_duration[7:0];

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  always_comb begin
    q_item.ei       = EI_TABLE[k_idx];
    q_item.ef       = EF_TABLE[f_idx];
    q_item.real_tok = token_valid;
    q_item.last     = last_token;
  end

endmodule

// ===== rtl/dlr_queue.sv =====
// Two-entry queue of classified tokens between front and back end.
module dlr_queue
  import dlr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  dlr_item_t push_item,
  input  logic      pop,
  output logic      full,
  output logic      not_empty,
  output dlr_item_t head
);

  dlr_item_t  slots [0:1];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = slots[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> not_empty)
    else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue count out of range");
`endif

endmodule

// ===== rtl/dlr_back.sv =====
// Back end: exp multiply, length scaling, frame accumulation and result register.
module dlr_back
  import dlr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [SCALE_W-1:0] cfg_wdata,
  input  logic               q_not_empty,
  input  dlr_item_t          q_head,
  output logic               q_pop,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [IDX_W-1:0]   token_index,
  output logic [DUR_W-1:0]   duration_frames,
  output logic [FRAME_W-1:0] start_frame,
  output logic [FRAME_W-1:0] end_frame,
  output logic [FRAME_W-1:0] seq_length,
  output logic               truncated,
  output logic               is_last
);

  typedef enum logic [2:0] {S_IDLE, S_LO, S_HI, S_MUL, S_ACC} state_t;

  state_t               state;
  dlr_item_t            item;
  logic [SCALE_W-1:0]   speed_scale;
  logic [TOTAL_W-1:0]   frame_total;
  logic [IDX_W-1:0]     token_count;
  logic [PROD_W-1:0]    p_lo;
  logic [PROD_W-1:0]    e_prod;
  logic [SCALED_W-1:0]  scaled;

  logic [PROD_W-1:0]    lo_mul;
  logic [PROD_W-1:0]    hi_mul;
  logic [PROD_W-1:0]    e_sum;
  logic [EXP_W-1:0]     e_val;
  logic [SCALED_W:0]    fr_sum;
  logic [FRAMES_W-1:0]  frames;
  logic [DUR_W-1:0]     dur;
  logic [TOTAL_W:0]     end_sum;
  logic [TOTAL_W-1:0]   end_val;
  logic [TOTAL_W-1:0]   len_val;
  logic [IDX_W:0]       cnt_inc;
  logic [IDX_W-1:0]     cnt_next;
  logic                 out_free;
  logic                 load;

  // Exp product in two halves of the fractional factor, rounding folded into the high step
  assign lo_mul = PROD_W'(item.ei) * PROD_W'(item.ef[EF_SPLIT-1:0]);
  assign hi_mul = PROD_W'(item.ei) * PROD_W'(item.ef[EF_W-1:EF_SPLIT]);
  assign e_sum  = (hi_mul << EF_SPLIT) + p_lo + (PROD_W'(1) << (EXP_SH - 1));
  assign e_val  = e_prod[EXP_SH +: EXP_W];

  // Ceiling of scaled exp, saturated duration, zero for padding tokens
  assign fr_sum = (SCALED_W+1)'(scaled) + ((SCALED_W+1)'(1) << FR_SH) - (SCALED_W+1)'(1);
  assign frames = fr_sum[SCALED_W:FR_SH];
  always_comb begin
    if (!item.real_tok) begin
      dur = '0;
    end else if (frames > FRAMES_W'(DUR_SAT)) begin
      dur = DUR_W'(DUR_SAT);
    end else begin
      dur = frames[DUR_W-1:0];
    end
  end

  // Running total with saturation
  assign end_sum = (TOTAL_W+1)'(frame_total) + (TOTAL_W+1)'(dur);
  assign end_val = (end_sum > (TOTAL_W+1)'(TOTAL_SAT)) ? TOTAL_W'(TOTAL_SAT)
                                                      : end_sum[TOTAL_W-1:0];
  assign len_val = (end_val == '0) ? TOTAL_W'(1) : end_val;

  // Token index wraps at the token limit
  assign cnt_inc  = (IDX_W+1)'(token_count) + (IDX_W+1)'(1);
  assign cnt_next = (cnt_inc >= (IDX_W+1)'(TOKEN_WRAP)) ? '0 : cnt_inc[IDX_W-1:0];

  assign out_free = !m_tvalid || m_tready;
  assign load     = (state == S_ACC) && out_free;
  assign q_pop    = (state == S_IDLE) && q_not_empty;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_scale <= SCALE_W'(4096);
    end else if (cfg_we) begin
      speed_scale <= cfg_wdata;
    end
  end

  // Sequencer, accumulators and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      frame_total <= '0;
      token_count <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      // Result valid: set on load, dropped once taken
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_not_empty) begin
            item  <= q_head;
            state <= q_head.real_tok ? S_LO : S_ACC;
          end
        end
        S_LO: begin
          p_lo  <= lo_mul;
          state <= S_HI;
        end
        S_HI: begin
          e_prod <= e_sum;
          state  <= S_MUL;
        end
        S_MUL: begin
          scaled <= SCALED_W'(e_val) * SCALED_W'(speed_scale);
          state  <= S_ACC;
        end
        S_ACC: begin
          if (out_free) begin
            token_index     <= token_count;
            duration_frames <= dur;
            start_frame     <= clip_frames(frame_total);
            end_frame       <= clip_frames(end_val);
            is_last         <= item.last;
            if (item.last) begin
              seq_length    <= clip_frames(len_val);
              truncated     <= (len_val > TOTAL_W'(MAX_FRAMES));
              frame_total   <= '0;
              token_count   <= '0;
            end else begin
              seq_length    <= '0;
              truncated     <= 1'b0;
              frame_total   <= end_val;
              token_count   <= cnt_next;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_clear_on_last: assert property (@(posedge clk) disable iff (rst)
      (load && item.last) |=> (frame_total == '0 && token_count == '0))
    else $error("running state not cleared after last token");
  a_padding_zero: assert property (@(posedge clk) disable iff (rst)
      (load && !item.real_tok) |=> (duration_frames == '0 && start_frame == end_frame))
    else $error("padding token produced frames");
  a_span_order: assert property (@(posedge clk) disable iff (rst)
      load |=> (start_frame <= end_frame))
    else $error("token span reversed");
  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
      (load && item.last) |=> (seq_length != '0 || MAX_FRAMES % (1 << FRAME_W) == 0))
    else $error("zero output length on last token");
`endif

endmodule
